// ----- rtl/core/prrs_pkg.sv -----
`default_nettype none
package prrs_pkg;

    localparam int PRIO_W  = 3;
    localparam int EV_W    = 8;
    localparam int SLICE_W = 16;
    localparam int EVC_W   = 9;

    localparam logic [EVC_W-1:0]   EVC_RESET   = 9'd256;
    localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd1;

    typedef enum logic [2:0] {
        OP_FORK   = 3'd0,
        OP_TICK   = 3'd1,
        OP_WAIT   = 3'd2,
        OP_SIGNAL = 3'd3,
        OP_FINISH = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        RC_OK      = 2'd0,
        RC_BAD_ARG = 2'd1,
        RC_FULL    = 2'd2,
        RC_NO_RUN  = 2'd3
    } rc_t;

    typedef enum logic {
        CFG_TIME_SLICE  = 1'b0,
        CFG_EVENT_COUNT = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TICK,
        ST_RS_TEST,
        ST_RS_HEAD,
        ST_INS_TEST,
        ST_INS_CMP,
        ST_SCAN_TEST,
        ST_SCAN_CHK,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        RET_FORK,
        RET_SCAN,
        RET_RESP
    } ret_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic              waiting;
        logic [EV_W-1:0]   ev;
    } th_word_t;

    typedef struct packed {
        logic capture;
        logic set_code;
        rc_t  code;
        logic fork_init;
        logic wait_mark;
        logic tick;
        logic clr_valid;
        logic rd_head;
        logic dispatch;
        logic swap;
        logic reload;
        logic ins_new;
        logic ins_rd;
        logic ins_shift;
        logic scan_clr;
        logic scan_rd;
        logic scan_wake;
        logic scan_inc;
        logic runs_clr;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       prio_bad;
        logic       full;
        logic       ev_bad;
        logic       cur_valid;
        logic       runs;
        logic       len_zero;
        logic       k_zero;
        logic       head_gt;
        logic       head_eq;
        logic       slice_zero;
        logic       ins_ge;
        logic       scan_done;
        logic       scan_hit;
    } sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/priority_round_robin_scheduler.sv -----
// Channel | Dir | Handshake          | Word
// s_      | in  | s_valid / s_ready  | s_opcode, s_priority_req, s_event_id
// m_      | out | m_valid / m_ready  | m_result_code, m_new_thread, m_woken_count,
//         |     |                    | m_running_thread, m_running_valid
// One command word at a time; s_ready is high only while idle.
// Each ready-queue insert walks the queue from its tail, entry by entry. Signal
// scans the thread table thread by thread, plus one insert per waiter woken.
// Reset (aresetn, synchronous) empties the queue and table; no clearing pass.
// The result holds in the output until m_ready; no new word is taken meanwhile.
`default_nettype none
module priority_round_robin_scheduler #(
    parameter int MAX_THREADS  = 32,
    parameter int MAX_PRIORITY = 5,
    parameter int MAX_EVENTS   = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_opcode,
    input  wire logic [2:0]  s_priority_req,
    input  wire logic [7:0]  s_event_id,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_result_code,
    output logic [4:0]       m_new_thread,
    output logic [5:0]       m_woken_count,
    output logic [4:0]       m_running_thread,
    output logic             m_running_valid,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    prrs_pkg::cmd_t cmd;
    prrs_pkg::sts_t sts;

    prrs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    prrs_dpath #(
        .MAX_THREADS  (MAX_THREADS),
        .MAX_PRIORITY (MAX_PRIORITY),
        .MAX_EVENTS   (MAX_EVENTS)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_opcode         (s_opcode),
        .s_priority_req   (s_priority_req),
        .s_event_id       (s_event_id),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .cmd              (cmd),
        .sts              (sts),
        .m_result_code    (m_result_code),
        .m_new_thread     (m_new_thread),
        .m_woken_count    (m_woken_count),
        .m_running_thread (m_running_thread),
        .m_running_valid  (m_running_valid)
    );

endmodule
`default_nettype wire

// ----- rtl/core/prrs_ctrl.sv -----
`default_nettype none
module prrs_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    input  wire prrs_pkg::sts_t sts,
    output prrs_pkg::cmd_t      cmd
);

    prrs_pkg::state_t state_reg, state_next;
    prrs_pkg::ret_t   ret_reg, ret_next;
    prrs_pkg::state_t ret_state;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= prrs_pkg::ST_IDLE;
            ret_reg   <= prrs_pkg::RET_RESP;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb begin
        unique case (ret_reg)
            prrs_pkg::RET_FORK:
                ret_state = sts.cur_valid ? prrs_pkg::ST_TICK : prrs_pkg::ST_RS_TEST;
            prrs_pkg::RET_SCAN: ret_state = prrs_pkg::ST_SCAN_TEST;
            default:            ret_state = prrs_pkg::ST_RESP;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            prrs_pkg::ST_IDLE: begin
                if (s_valid) state_next = prrs_pkg::ST_DECODE;
            end
            prrs_pkg::ST_DECODE: begin
                state_next = prrs_pkg::ST_RESP;
                unique case (prrs_pkg::op_t'(sts.op))
                    prrs_pkg::OP_FORK: begin
                        if (!sts.prio_bad && !sts.full) begin
                            ret_next   = prrs_pkg::RET_FORK;
                            state_next = prrs_pkg::ST_INS_TEST;
                        end
                    end
                    prrs_pkg::OP_TICK:
                        if (sts.cur_valid) state_next = prrs_pkg::ST_TICK;
                    prrs_pkg::OP_WAIT:
                        if (!sts.ev_bad && sts.cur_valid) state_next = prrs_pkg::ST_TICK;
                    prrs_pkg::OP_SIGNAL:
                        if (!sts.ev_bad) state_next = prrs_pkg::ST_SCAN_TEST;
                    prrs_pkg::OP_FINISH:
                        if (sts.cur_valid) state_next = prrs_pkg::ST_RS_TEST;
                    default: state_next = prrs_pkg::ST_RESP;
                endcase
            end
            prrs_pkg::ST_TICK: state_next = prrs_pkg::ST_RS_TEST;
            prrs_pkg::ST_RS_TEST:
                state_next = sts.len_zero ? prrs_pkg::ST_RESP : prrs_pkg::ST_RS_HEAD;
            prrs_pkg::ST_RS_HEAD: begin
                state_next = prrs_pkg::ST_RESP;
                if (sts.runs && (sts.head_gt || (sts.slice_zero && sts.head_eq))) begin
                    ret_next   = prrs_pkg::RET_RESP;
                    state_next = prrs_pkg::ST_INS_TEST;
                end
            end
            prrs_pkg::ST_INS_TEST:
                state_next = sts.k_zero ? ret_state : prrs_pkg::ST_INS_CMP;
            prrs_pkg::ST_INS_CMP:
                state_next = sts.ins_ge ? ret_state : prrs_pkg::ST_INS_TEST;
            prrs_pkg::ST_SCAN_TEST: begin
                if (!sts.scan_done) begin
                    state_next = prrs_pkg::ST_SCAN_CHK;
                end else begin
                    state_next = sts.cur_valid ? prrs_pkg::ST_TICK : prrs_pkg::ST_RS_TEST;
                end
            end
            prrs_pkg::ST_SCAN_CHK: begin
                if (sts.scan_hit) begin
                    ret_next   = prrs_pkg::RET_SCAN;
                    state_next = prrs_pkg::ST_INS_TEST;
                end else begin
                    state_next = prrs_pkg::ST_SCAN_TEST;
                end
            end
            prrs_pkg::ST_RESP: begin
                if (m_ready) state_next = prrs_pkg::ST_IDLE;
            end
            default: state_next = prrs_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            prrs_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            prrs_pkg::ST_DECODE: begin
                unique case (prrs_pkg::op_t'(sts.op))
                    prrs_pkg::OP_FORK: begin
                        if (sts.prio_bad) begin
                            cmd.set_code = 1'b1;
                            cmd.code     = prrs_pkg::RC_BAD_ARG;
                        end else if (sts.full) begin
                            cmd.set_code = 1'b1;
                            cmd.code     = prrs_pkg::RC_FULL;
                        end else begin
                            cmd.fork_init = 1'b1;
                        end
                    end
                    prrs_pkg::OP_TICK: begin
                        if (!sts.cur_valid) begin
                            cmd.set_code = 1'b1;
                            cmd.code     = prrs_pkg::RC_NO_RUN;
                        end
                    end
                    prrs_pkg::OP_WAIT: begin
                        if (sts.ev_bad) begin
                            cmd.set_code = 1'b1;
                            cmd.code     = prrs_pkg::RC_BAD_ARG;
                        end else if (!sts.cur_valid) begin
                            cmd.set_code = 1'b1;
                            cmd.code     = prrs_pkg::RC_NO_RUN;
                        end else begin
                            cmd.wait_mark = 1'b1;
                            cmd.runs_clr  = 1'b1;
                        end
                    end
                    prrs_pkg::OP_SIGNAL: begin
                        if (sts.ev_bad) begin
                            cmd.set_code = 1'b1;
                            cmd.code     = prrs_pkg::RC_BAD_ARG;
                        end else begin
                            cmd.scan_clr = 1'b1;
                        end
                    end
                    prrs_pkg::OP_FINISH: begin
                        if (!sts.cur_valid) begin
                            cmd.set_code = 1'b1;
                            cmd.code     = prrs_pkg::RC_NO_RUN;
                        end else begin
                            cmd.runs_clr = 1'b1;
                        end
                    end
                    default: begin
                        cmd.set_code = 1'b1;
                        cmd.code     = prrs_pkg::RC_BAD_ARG;
                    end
                endcase
            end
            prrs_pkg::ST_TICK: cmd.tick = 1'b1;
            prrs_pkg::ST_RS_TEST: begin
                if (sts.len_zero) begin
                    cmd.clr_valid = sts.cur_valid && !sts.runs;
                end else begin
                    cmd.rd_head = 1'b1;
                end
            end
            prrs_pkg::ST_RS_HEAD: begin
                if (!sts.runs) begin
                    cmd.dispatch = 1'b1;
                end else if (sts.head_gt || (sts.slice_zero && sts.head_eq)) begin
                    cmd.dispatch = 1'b1;
                    cmd.swap     = 1'b1;
                end else if (sts.slice_zero) begin
                    cmd.reload = 1'b1;
                end
            end
            prrs_pkg::ST_INS_TEST: begin
                if (sts.k_zero) cmd.ins_new = 1'b1;
                else            cmd.ins_rd  = 1'b1;
            end
            prrs_pkg::ST_INS_CMP: begin
                if (sts.ins_ge) cmd.ins_new   = 1'b1;
                else            cmd.ins_shift = 1'b1;
            end
            prrs_pkg::ST_SCAN_TEST: cmd.scan_rd = !sts.scan_done;
            prrs_pkg::ST_SCAN_CHK: begin
                if (sts.scan_hit) cmd.scan_wake = 1'b1;
                else              cmd.scan_inc  = 1'b1;
            end
            prrs_pkg::ST_RESP: m_valid = 1'b1;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/prrs_dpath.sv -----
`default_nettype none
module prrs_dpath #(
    parameter int MAX_THREADS  = 32,
    parameter int MAX_PRIORITY = 5,
    parameter int MAX_EVENTS   = 256
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic [2:0]     s_opcode,
    input  wire logic [2:0]     s_priority_req,
    input  wire logic [7:0]     s_event_id,
    input  wire logic           cfg_we,
    input  wire logic [0:0]     cfg_addr,
    input  wire logic [15:0]    cfg_wdata,
    input  wire prrs_pkg::cmd_t cmd,
    output prrs_pkg::sts_t      sts,
    output logic [1:0]          m_result_code,
    output logic [4:0]          m_new_thread,
    output logic [5:0]          m_woken_count,
    output logic [4:0]          m_running_thread,
    output logic                m_running_valid
);

    localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int CW = $clog2(MAX_THREADS + 1);
    localparam int QD = 1 << TW;
    localparam int PW = prrs_pkg::PRIO_W;
    localparam int QW = PW + TW;

    prrs_pkg::th_word_t th_mem [MAX_THREADS];
    logic [QW-1:0]      q_mem  [QD];

    logic [2:0]                    op_reg, op_next;
    logic [PW-1:0]                 prio_reg, prio_next;
    logic [prrs_pkg::EV_W-1:0]     ev_reg, ev_next;
    prrs_pkg::rc_t                 code_reg, code_next;
    logic [TW-1:0]                 new_reg, new_next;
    logic [CW-1:0]                 woken_reg, woken_next;
    logic [CW-1:0]                 made_reg, made_next;
    logic [CW-1:0]                 len_reg, len_next;
    logic [TW-1:0]                 hd_reg, hd_next;
    logic [CW-1:0]                 k_reg, k_next;
    logic [TW-1:0]                 cur_reg, cur_next;
    logic [PW-1:0]                 cprio_reg, cprio_next;
    logic                          cvalid_reg, cvalid_next;
    logic                          runs_reg, runs_next;
    logic [prrs_pkg::SLICE_W-1:0]  slice_reg, slice_next;
    logic [prrs_pkg::SLICE_W-1:0]  ts_reg, ts_next;
    logic [prrs_pkg::EVC_W-1:0]    evc_reg, evc_next;
    logic [TW-1:0]                 iid_reg, iid_next;
    logic [PW-1:0]                 ip_reg, ip_next;
    logic [CW-1:0]                 t_reg, t_next;
    logic [QW-1:0]                 q_rd_reg;
    prrs_pkg::th_word_t            th_rd_reg;

    logic [PW-1:0]          q_rd_prio;
    logic [TW-1:0]          q_rd_id;
    logic [TW-1:0]          q_wa, q_ra;
    logic                   q_we;
    logic [QW-1:0]          q_wd;
    logic                   th_we;
    logic [TW-1:0]          th_wa;
    prrs_pkg::th_word_t     th_wd;
    logic [prrs_pkg::EVC_W-1:0] cfg_evc;

    assign q_rd_prio = q_rd_reg[QW-1:TW];
    assign q_rd_id   = q_rd_reg[TW-1:0];
    assign q_wa      = hd_reg + k_reg[TW-1:0];
    assign q_ra      = cmd.rd_head ? hd_reg : TW'(hd_reg + k_reg[TW-1:0] - 1'b1);
    assign q_we      = cmd.ins_new || cmd.ins_shift;
    assign q_wd      = cmd.ins_new ? {ip_reg, iid_reg} : q_rd_reg;
    assign cfg_evc   = cfg_wdata[prrs_pkg::EVC_W-1:0];

    always_comb begin
        th_we = cmd.fork_init || cmd.wait_mark || cmd.scan_wake;
        th_wa = t_reg[TW-1:0];
        th_wd = '{prio: th_rd_reg.prio, waiting: 1'b0, ev: th_rd_reg.ev};
        if (cmd.fork_init) begin
            th_wa = made_reg[TW-1:0];
            th_wd = '{prio: prio_reg, waiting: 1'b0, ev: '0};
        end else if (cmd.wait_mark) begin
            th_wa = cur_reg;
            th_wd = '{prio: cprio_reg, waiting: 1'b1, ev: ev_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (th_we) th_mem[th_wa] <= th_wd;
        if (cmd.scan_rd) th_rd_reg <= th_mem[t_reg[TW-1:0]];
        if (q_we) q_mem[q_wa] <= q_wd;
        if (cmd.rd_head || cmd.ins_rd) q_rd_reg <= q_mem[q_ra];
    end

    always_comb begin
        op_next     = op_reg;
        prio_next   = prio_reg;
        ev_next     = ev_reg;
        code_next   = code_reg;
        new_next    = new_reg;
        woken_next  = woken_reg;
        made_next   = made_reg;
        len_next    = len_reg;
        hd_next     = hd_reg;
        k_next      = k_reg;
        cur_next    = cur_reg;
        cprio_next  = cprio_reg;
        cvalid_next = cvalid_reg;
        runs_next   = runs_reg;
        slice_next  = slice_reg;
        ts_next     = ts_reg;
        evc_next    = evc_reg;
        iid_next    = iid_reg;
        ip_next     = ip_reg;
        t_next      = t_reg;

        if (cfg_we) begin
            unique case (prrs_pkg::cfg_idx_t'(cfg_addr))
                prrs_pkg::CFG_TIME_SLICE:
                    ts_next = (cfg_wdata == '0) ? prrs_pkg::SLICE_RESET : cfg_wdata;
                prrs_pkg::CFG_EVENT_COUNT:
                    evc_next = (cfg_evc > prrs_pkg::EVC_W'(MAX_EVENTS))
                               ? prrs_pkg::EVC_W'(MAX_EVENTS) : cfg_evc;
            endcase
        end

        if (cmd.capture) begin
            op_next    = s_opcode;
            prio_next  = s_priority_req;
            ev_next    = s_event_id;
            code_next  = prrs_pkg::RC_OK;
            new_next   = '0;
            woken_next = '0;
            runs_next  = cvalid_reg;
        end
        if (cmd.set_code) code_next = cmd.code;
        if (cmd.runs_clr) runs_next = 1'b0;
        if (cmd.fork_init) begin
            new_next  = made_reg[TW-1:0];
            iid_next  = made_reg[TW-1:0];
            ip_next   = prio_reg;
            made_next = made_reg + 1'b1;
            k_next    = len_reg;
        end
        if (cmd.tick && slice_reg != '0) slice_next = slice_reg - 1'b1;
        if (cmd.clr_valid) cvalid_next = 1'b0;
        if (cmd.reload) slice_next = ts_reg;
        if (cmd.dispatch) begin
            cur_next    = q_rd_id;
            cprio_next  = q_rd_prio;
            cvalid_next = 1'b1;
            runs_next   = 1'b1;
            hd_next     = hd_reg + 1'b1;
            len_next    = len_reg - 1'b1;
            slice_next  = ts_reg;
        end
        if (cmd.swap) begin
            iid_next = cur_reg;
            ip_next  = cprio_reg;
            k_next   = len_reg - 1'b1;
        end
        if (cmd.ins_new) len_next = len_reg + 1'b1;
        if (cmd.ins_shift) k_next = k_reg - 1'b1;
        if (cmd.scan_clr) t_next = '0;
        if (cmd.scan_inc) t_next = t_reg + 1'b1;
        if (cmd.scan_wake) begin
            iid_next   = t_reg[TW-1:0];
            ip_next    = th_rd_reg.prio;
            k_next     = len_reg;
            woken_next = woken_reg + 1'b1;
            t_next     = t_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            made_reg   <= '0;
            len_reg    <= '0;
            hd_reg     <= '0;
            cur_reg    <= '0;
            cvalid_reg <= 1'b0;
            runs_reg   <= 1'b0;
            slice_reg  <= '0;
            ts_reg     <= prrs_pkg::SLICE_RESET;
            evc_reg    <= prrs_pkg::EVC_RESET;
            code_reg   <= prrs_pkg::RC_OK;
            new_reg    <= '0;
            woken_reg  <= '0;
        end else begin
            made_reg   <= made_next;
            len_reg    <= len_next;
            hd_reg     <= hd_next;
            cur_reg    <= cur_next;
            cvalid_reg <= cvalid_next;
            runs_reg   <= runs_next;
            slice_reg  <= slice_next;
            ts_reg     <= ts_next;
            evc_reg    <= evc_next;
            code_reg   <= code_next;
            new_reg    <= new_next;
            woken_reg  <= woken_next;
        end
        op_reg    <= op_next;
        prio_reg  <= prio_next;
        ev_reg    <= ev_next;
        k_reg     <= k_next;
        cprio_reg <= cprio_next;
        iid_reg   <= iid_next;
        ip_reg    <= ip_next;
        t_reg     <= t_next;
    end

    always_comb begin
        sts.op         = op_reg;
        sts.prio_bad   = prio_reg > PW'(MAX_PRIORITY);
        sts.full       = made_reg >= CW'(MAX_THREADS);
        sts.ev_bad     = {1'b0, ev_reg} >= evc_reg;
        sts.cur_valid  = cvalid_reg;
        sts.runs       = runs_reg;
        sts.len_zero   = len_reg == '0;
        sts.k_zero     = k_reg == '0;
        sts.head_gt    = q_rd_prio > cprio_reg;
        sts.head_eq    = q_rd_prio == cprio_reg;
        sts.slice_zero = slice_reg == '0;
        sts.ins_ge     = q_rd_prio >= ip_reg;
        sts.scan_done  = t_reg >= made_reg;
        sts.scan_hit   = th_rd_reg.waiting && (th_rd_reg.ev == ev_reg);
    end

    assign m_result_code    = code_reg;
    assign m_new_thread     = 5'(new_reg);
    assign m_woken_count    = 6'(woken_reg);
    assign m_running_thread = cvalid_reg ? 5'(cur_reg) : 5'd0;
    assign m_running_valid  = cvalid_reg;

endmodule
`default_nettype wire

// ----- rtl/core/prrs_checker.sv -----
`default_nettype none
module prrs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [2:0]  s_opcode,
    input wire logic [2:0]  s_priority_req,
    input wire logic [7:0]  s_event_id,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_result_code,
    input wire logic [4:0]  m_new_thread,
    input wire logic [5:0]  m_woken_count,
    input wire logic [4:0]  m_running_thread,
    input wire logic        m_running_valid,
    input wire logic        cfg_we,
    input wire logic [0:0]  cfg_addr,
    input wire logic [15:0] cfg_wdata
);

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("word taken while busy");

    a_idle_thread_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_running_valid) |-> (m_running_thread == 5'd0))
        else $error("thread id shown with nothing running");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_code != prrs_pkg::RC_OK)
        |-> (m_new_thread == 5'd0 && m_woken_count == 6'd0))
        else $error("error result carries fork or wake data");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result_code)
        && $stable(m_running_thread) && $stable(m_woken_count)))
        else $error("stalled result changed");

endmodule

bind priority_round_robin_scheduler prrs_checker u_prrs_checker (.*);
`default_nettype wire

// ----- tb/sv/tb_priority_round_robin_scheduler.sv -----
`default_nettype none
module tb_priority_round_robin_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_THREADS = 32;
    localparam int TOP_PRIO  = 5;
    localparam int N_EVENTS  = 256;

    localparam logic [2:0] TH_READY = 3'd1;
    localparam logic [2:0] TH_RUN   = 3'd2;
    localparam logic [2:0] TH_WAIT  = 3'd3;
    localparam logic [2:0] TH_DONE  = 3'd4;

    typedef struct {
        prrs_pkg::rc_t code;
        logic [4:0]    made_id;
        logic [5:0]    woken;
        logic [4:0]    run_id;
        logic          run_ok;
    } sched_word_t;

    class sched_scoreboard;
        logic [2:0] th_prio[N_THREADS];
        logic [2:0] th_state[N_THREADS];
        logic [7:0] th_ev[N_THREADS];
        int         rq[N_THREADS];
        int         rq_len;
        int         made;
        int         cur;
        bit         cur_ok;
        int         slice_left;
        int         slice_len = 1;
        int         ev_limit = N_EVENTS;
        sched_word_t pending[$];
        int         errors;

        function void write_reg(prrs_pkg::cfg_idx_t idx, logic [15:0] v);
            if (idx == prrs_pkg::CFG_TIME_SLICE)
                slice_len = (v == 0) ? 1 : int'(v);
            else
                ev_limit = (v[8:0] > N_EVENTS) ? N_EVENTS : int'(v[8:0]);
        endfunction

        function void enqueue(int t);
            int pos;
            pos = 0;
            if (rq_len >= N_THREADS) return;
            while (pos < rq_len && th_prio[rq[pos]] >= th_prio[t]) pos++;
            for (int k = rq_len; k > pos; k--) rq[k] = rq[k-1];
            rq[pos] = t;
            rq_len++;
            th_state[t] = TH_READY;
        endfunction

        function void dispatch();
            cur = rq[0];
            for (int k = 1; k < rq_len; k++) rq[k-1] = rq[k];
            rq_len--;
            cur_ok = 1;
            th_state[cur] = TH_RUN;
            slice_left = slice_len;
        endfunction

        function void resched();
            bit runs;
            int prev;
            runs = cur_ok && th_state[cur] == TH_RUN;
            if (rq_len == 0) begin
                if (cur_ok && !runs) cur_ok = 0;
                return;
            end
            if (!runs) begin
                dispatch();
                return;
            end
            prev = cur;
            if (th_prio[cur] < th_prio[rq[0]] ||
                (slice_left == 0 && th_prio[cur] == th_prio[rq[0]])) begin
                dispatch();
                enqueue(prev);
            end else if (slice_left == 0) begin
                slice_left = slice_len;
            end
        endfunction

        function void tick();
            if (slice_left > 0) slice_left--;
            resched();
        endfunction

        function void note(logic [2:0] op, logic [2:0] pr, logic [7:0] ev);
            sched_word_t w;
            w.code = prrs_pkg::RC_OK;
            w.made_id = '0;
            w.woken = '0;
            case (op)
                prrs_pkg::OP_FORK: begin
                    if (pr > TOP_PRIO) w.code = prrs_pkg::RC_BAD_ARG;
                    else if (made >= N_THREADS) w.code = prrs_pkg::RC_FULL;
                    else begin
                        th_prio[made] = pr;
                        th_ev[made] = 0;
                        enqueue(made);
                        w.made_id = made[4:0];
                        made++;
                        if (cur_ok) tick(); else resched();
                    end
                end
                prrs_pkg::OP_TICK: begin
                    if (!cur_ok) w.code = prrs_pkg::RC_NO_RUN;
                    else tick();
                end
                prrs_pkg::OP_WAIT: begin
                    if (ev >= ev_limit) w.code = prrs_pkg::RC_BAD_ARG;
                    else if (!cur_ok) w.code = prrs_pkg::RC_NO_RUN;
                    else begin
                        th_state[cur] = TH_WAIT;
                        th_ev[cur] = ev;
                        tick();
                    end
                end
                prrs_pkg::OP_SIGNAL: begin
                    if (ev >= ev_limit) w.code = prrs_pkg::RC_BAD_ARG;
                    else begin
                        for (int t = 0; t < made; t++)
                            if (th_state[t] == TH_WAIT && th_ev[t] == ev) begin
                                enqueue(t);
                                w.woken++;
                            end
                        if (cur_ok) tick(); else resched();
                    end
                end
                prrs_pkg::OP_FINISH: begin
                    if (!cur_ok) w.code = prrs_pkg::RC_NO_RUN;
                    else begin
                        th_state[cur] = TH_DONE;
                        resched();
                    end
                end
                default: w.code = prrs_pkg::RC_BAD_ARG;
            endcase
            w.run_id = cur_ok ? cur[4:0] : 5'd0;
            w.run_ok = cur_ok;
            pending.push_back(w);
        endfunction

        function void check(logic [1:0] rc, logic [4:0] nt, logic [5:0] wk,
                            logic [4:0] rt, logic rv);
            sched_word_t w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word code=%0d", $time, rc);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (rc !== w.code) begin
                $display("%0t: result_code exp %0d got %0d", $time, w.code, rc);
                errors++;
            end
            if (nt !== w.made_id) begin
                $display("%0t: new_thread exp %0d got %0d", $time, w.made_id, nt);
                errors++;
            end
            if (wk !== w.woken) begin
                $display("%0t: woken_count exp %0d got %0d", $time, w.woken, wk);
                errors++;
            end
            if (rt !== w.run_id) begin
                $display("%0t: running_thread exp %0d got %0d", $time, w.run_id, rt);
                errors++;
            end
            if (rv !== w.run_ok) begin
                $display("%0t: running_valid exp %0d got %0d", $time, w.run_ok, rv);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_opcode = '0;
    logic [2:0]  s_priority_req = '0;
    logic [7:0]  s_event_id = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_result_code;
    logic [4:0]  m_new_thread;
    logic [5:0]  m_woken_count;
    logic [4:0]  m_running_thread;
    logic        m_running_valid;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;

    sched_scoreboard sb = new;
    int unsigned burst_left;
    int unsigned rx_cyc;

    priority_round_robin_scheduler dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_opcode(s_opcode), .s_priority_req(s_priority_req), .s_event_id(s_event_id),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_code(m_result_code), .m_new_thread(m_new_thread),
        .m_woken_count(m_woken_count), .m_running_thread(m_running_thread),
        .m_running_valid(m_running_valid),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #200_000_000;
        $display("priority_round_robin_scheduler verification failed");
        $finish;
    end

    // result side: stall pattern is chosen by bits 9:8 of rx_cyc
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_cyc <= 0;
        end else begin
            if (m_valid && m_ready)
                sb.check(m_result_code, m_new_thread, m_woken_count,
                         m_running_thread, m_running_valid);
            rx_cyc <= rx_cyc + 1;
            case (rx_cyc[9:8])
                2'd0: m_ready <= 1'b1;
                2'd1: m_ready <= ($urandom % 3) != 0;
                2'd2: m_ready <= rx_cyc[4:0] > 5'd24;
                default: m_ready <= ($urandom % 8) == 0;
            endcase
        end
    end

    task automatic send_word(logic [2:0] op, logic [2:0] pr, logic [7:0] ev);
        s_valid <= 1'b1;
        s_opcode <= op;
        s_priority_req <= pr;
        s_event_id <= ev;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note(op, pr, ev);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            burst_left = $urandom_range(0, 20);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(prrs_pkg::cfg_idx_t idx, logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, v);
    endtask

    task automatic random_word();
        int unsigned r;
        logic [2:0] pr;
        logic [7:0] ev;
        r = $urandom_range(0, 999);
        pr = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        ev = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        if (r < 25)       send_word(prrs_pkg::OP_FORK, pr, ev);
        else if (r < 45)  send_word(3'($urandom_range(5, 7)), pr, ev);
        else if (r < 500) send_word(prrs_pkg::OP_TICK, pr, ev);
        else if (r < 720) send_word(prrs_pkg::OP_WAIT, pr, ev);
        else if (r < 980) send_word(prrs_pkg::OP_SIGNAL, pr, ev);
        else              send_word(prrs_pkg::OP_FINISH, pr, ev);
    endtask

    initial begin
        logic [15:0] slice_set[5];
        logic [15:0] evc_set[5];
        slice_set = '{16'd0, 16'd65535, 16'd3, 16'd2, 16'd1};
        evc_set   = '{16'd4, 16'd0, 16'd16, 16'd511, 16'd256};
        burst_left = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        send_word(prrs_pkg::OP_TICK, 3'd0, 8'd0);
        send_word(prrs_pkg::OP_WAIT, 3'd0, 8'd0);
        send_word(prrs_pkg::OP_FINISH, 3'd0, 8'd0);
        send_word(prrs_pkg::OP_SIGNAL, 3'd0, 8'd0);
        for (int op = 5; op < 8; op++) send_word(3'(op), 3'd7, 8'hff);
        send_word(prrs_pkg::OP_FORK, 3'd7, 8'd0);
        send_word(prrs_pkg::OP_FORK, 3'd6, 8'd0);
        send_word(prrs_pkg::OP_FORK, 3'd0, 8'd0);
        send_word(prrs_pkg::OP_FORK, 3'd5, 8'd0);
        send_word(prrs_pkg::OP_FORK, 3'd5, 8'd0);
        send_word(prrs_pkg::OP_TICK, 3'd0, 8'd0);
        send_word(prrs_pkg::OP_TICK, 3'd0, 8'd0);
        send_word(prrs_pkg::OP_WAIT, 3'd0, 8'd255);
        send_word(prrs_pkg::OP_SIGNAL, 3'd0, 8'd255);
        send_word(prrs_pkg::OP_WAIT, 3'd0, 8'd3);
        send_word(prrs_pkg::OP_WAIT, 3'd0, 8'd3);
        send_word(prrs_pkg::OP_WAIT, 3'd0, 8'd3);
        send_word(prrs_pkg::OP_SIGNAL, 3'd0, 8'd3);
        send_word(prrs_pkg::OP_FINISH, 3'd0, 8'd0);
        send_word(prrs_pkg::OP_FINISH, 3'd0, 8'd0);
        send_word(prrs_pkg::OP_TICK, 3'd0, 8'd0);

        for (int ph = 0; ph < 5; ph++) begin
            drain();
            cfg_write(prrs_pkg::CFG_TIME_SLICE, slice_set[ph]);
            cfg_write(prrs_pkg::CFG_EVENT_COUNT, evc_set[ph]);
            burst_left = (ph == 1) ? 0 : $urandom_range(0, 20);
            for (int i = 0; i < 340; i++) begin
                if (ph == 2 && i == 170) drain();
                random_word();
            end
        end

        drain();
        repeat (100) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("priority_round_robin_scheduler verification clean");
        else
            $display("priority_round_robin_scheduler verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
rtl/core/prrs_pkg.sv
rtl/core/prrs_ctrl.sv
rtl/core/prrs_dpath.sv
rtl/core/priority_round_robin_scheduler.sv
rtl/core/prrs_checker.sv
tb/sv/tb_priority_round_robin_scheduler.sv
